// ===== hw/rtl/prr_pkg.sv =====
`timescale 1ns / 1ps

package prr_pkg;

    // Frame size defaults
    localparam int IMAGE_WIDTH_DEF  = 512;
    localparam int IMAGE_HEIGHT_DEF = 512;

    // Field and datapath widths
    localparam int COORD_W    = 9;                    // pixel and target coordinates
    localparam int DEPTH_W    = 16;
    localparam int ROT_W      = 16;                   // signed Q2.14
    localparam int FOC_W      = 20;                   // unsigned Q12.8
    localparam int OFS_W      = 13;                   // coord minus centre, any frame size
    localparam int PRD_W      = ROT_W + OFS_W;        // rotation x offset
    localparam int PRF_W      = ROT_W + FOC_W + 1;    // rotation x focal length
    localparam int FRAC_W     = 22;                   // sum scale 2^22
    localparam int SUM_W      = 42;
    localparam int INT_W      = SUM_W - FRAC_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = FOC_W;

    // Register reset values
    localparam logic [ROT_W-1:0] ROT_ONE   = ROT_W'(16384);
    localparam logic [ROT_W-1:0] ROT_ZERO  = '0;
    localparam logic [FOC_W-1:0] FOCAL_RST = FOC_W'(128000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_UU = 3'd0,
        CFG_ROT_UV = 3'd1,
        CFG_ROT_UZ = 3'd2,
        CFG_ROT_VU = 3'd3,
        CFG_ROT_VV = 3'd4,
        CFG_ROT_VZ = 3'd5,
        CFG_FOCAL  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_col;
        logic [COORD_W-1:0] pixel_row;
        logic [DEPTH_W-1:0] pixel_depth;
        logic               vein_on;
    } t_pixel_in;

    typedef struct packed {
        logic [COORD_W-1:0] target_col;
        logic [COORD_W-1:0] target_row;
    } t_pixel_out;

    // Per-axis result handed from a lane to the output stage
    typedef struct packed {
        logic [COORD_W-1:0] coord;
        logic               in_frame;
    } t_lane_res;

endpackage

// ===== hw/rtl/prr_lane.sv =====
`timescale 1ns / 1ps

module prr_lane
    import prr_pkg::*;
#(
    parameter int LIMIT  = IMAGE_WIDTH_DEF,
    parameter int CENTRE = IMAGE_WIDTH_DEF / 2
) (
    input  logic                    i_clk,
    input  logic signed [OFS_W-1:0] i_du,
    input  logic signed [OFS_W-1:0] i_dv,
    input  logic signed [ROT_W-1:0] i_ra,
    input  logic signed [ROT_W-1:0] i_rb,
    input  logic signed [ROT_W-1:0] i_rc,
    input  logic        [FOC_W-1:0] i_focal,
    output t_lane_res               o_res
);

    localparam logic signed [SUM_W-1:0] CTR_SC = SUM_W'(CENTRE) <<< FRAC_W;
    localparam logic [INT_W-1:0]        LIM_I  = INT_W'(LIMIT);

    logic signed [PRD_W-1:0] r_pa, r_pb, n_pa, n_pb;
    logic signed [PRF_W-1:0] r_pc, n_pc;
    logic signed [FOC_W:0]   w_focal;
    logic signed [SUM_W-1:0] r_s, n_s, w_ab;
    logic        [INT_W-1:0] n_q;
    logic                    n_up;
    t_lane_res               r_res, n_res;

    // Stage 1: products
    always_comb begin
        w_focal = $signed({1'b0, i_focal});
        n_pa    = i_ra * i_du;
        n_pb    = i_rb * i_dv;
        n_pc    = i_rc * w_focal;
    end

    // Stage 2: exact sum at scale 2^22
    always_comb begin
        w_ab = {{(SUM_W-PRD_W){r_pa[PRD_W-1]}}, r_pa}
             + {{(SUM_W-PRD_W){r_pb[PRD_W-1]}}, r_pb};
        n_s  = (w_ab <<< 8)
             + {{(SUM_W-PRF_W){r_pc[PRF_W-1]}}, r_pc}
             + CTR_SC;
    end

    // Stage 3: truncate toward zero, then check against the frame
    always_comb begin
        n_up           = r_s[SUM_W-1] && (|r_s[FRAC_W-1:0]);
        n_q            = r_s[SUM_W-1:FRAC_W] + INT_W'(n_up);
        n_res.coord    = n_q[COORD_W-1:0];
        n_res.in_frame = !n_q[INT_W-1] && (n_q < LIM_I);
    end

    always_ff @(posedge i_clk) begin
        r_pa  <= n_pa;
        r_pb  <= n_pb;
        r_pc  <= n_pc;
        r_s   <= n_s;
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

// ===== hw/rtl/pixel_rotate_reproject_core.sv =====
`timescale 1ns / 1ps

// Pipeline: a transferred pixel moves through the offset, products, sum and clip
// registers in order, and its result strobe rises from the out register.
// Throughput: one pixel per cycle, every cycle; o_busy is low outside reset.
// Reset: synchronous, active low; flushes all valid bits, restores the
// identity rotation and 500.0 px focal length, holds o_busy high meanwhile.
// The receiver cannot stall: each result is shown for one cycle only.
module pixel_rotate_reproject_core
    import prr_pkg::*;
#(
    parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  t_pixel_in             i_pixel,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_valid,
    output t_pixel_out            o_target
);

    // Image centre, rounded down, as a signed offset operand
    localparam logic signed [OFS_W-1:0] CX = OFS_W'(IMAGE_WIDTH / 2);
    localparam logic signed [OFS_W-1:0] CY = OFS_W'(IMAGE_HEIGHT / 2);

    // Configuration registers
    logic signed [ROT_W-1:0] r_rot_uu, r_rot_uv, r_rot_uz;
    logic signed [ROT_W-1:0] r_rot_vu, r_rot_vv, r_rot_vz;
    logic        [FOC_W-1:0] r_focal;

    // Pipeline control
    logic r_busy;
    logic r_v0, r_v1, r_v2, r_v3;
    logic r_out_vld;
    logic n_v0;

    // Stage 0 payload
    logic signed [OFS_W-1:0] r_du, r_dv, n_du, n_dv;

    t_lane_res  w_col_res, w_row_res;
    t_pixel_out r_target;

    // Configuration writes: software must load these only while the pipe is empty; the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_uu <= ROT_ONE;
            r_rot_uv <= ROT_ZERO;
            r_rot_uz <= ROT_ZERO;
            r_rot_vu <= ROT_ZERO;
            r_rot_vv <= ROT_ONE;
            r_rot_vz <= ROT_ZERO;
            r_focal  <= FOCAL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROT_UU: r_rot_uu <= i_cfg_data[ROT_W-1:0];
                CFG_ROT_UV: r_rot_uv <= i_cfg_data[ROT_W-1:0];
                CFG_ROT_UZ: r_rot_uz <= i_cfg_data[ROT_W-1:0];
                CFG_ROT_VU: r_rot_vu <= i_cfg_data[ROT_W-1:0];
                CFG_ROT_VV: r_rot_vv <= i_cfg_data[ROT_W-1:0];
                CFG_ROT_VZ: r_rot_vz <= i_cfg_data[ROT_W-1:0];
                CFG_FOCAL:  r_focal  <= i_cfg_data[FOC_W-1:0];
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    // Stage 0: qualify the transfer and center the source coordinates.
    // Drop unflagged pixels and pixels with no depth right here; they only
    // travel down the pipe as a cleared valid bit.
    always_comb begin
        n_v0 = i_start && !r_busy && i_pixel.vein_on && (|i_pixel.pixel_depth);
        n_du = $signed({{(OFS_W-COORD_W){1'b0}}, i_pixel.pixel_col}) - CX;
        n_dv = $signed({{(OFS_W-COORD_W){1'b0}}, i_pixel.pixel_row}) - CY;
    end

    always_ff @(posedge i_clk) begin
        r_du <= n_du;
        r_dv <= n_dv;
    end

    // Stages 1 to 3: one lane per target axis
    prr_lane #(
        .LIMIT  (IMAGE_WIDTH),
        .CENTRE (IMAGE_WIDTH / 2)
    ) u_lane_col (
        .i_clk   (i_clk),
        .i_du    (r_du),
        .i_dv    (r_dv),
        .i_ra    (r_rot_uu),
        .i_rb    (r_rot_uv),
        .i_rc    (r_rot_uz),
        .i_focal (r_focal),
        .o_res   (w_col_res)
    );

    prr_lane #(
        .LIMIT  (IMAGE_HEIGHT),
        .CENTRE (IMAGE_HEIGHT / 2)
    ) u_lane_row (
        .i_clk   (i_clk),
        .i_du    (r_du),
        .i_dv    (r_dv),
        .i_ra    (r_rot_vu),
        .i_rb    (r_rot_vv),
        .i_rc    (r_rot_vz),
        .i_focal (r_focal),
        .o_res   (w_row_res)
    );

    // Valid bits advance in step with the lane registers; a pixel whose
    // target falls outside the frame on either axis is dropped at the output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_v0      <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_busy    <= 1'b0;
            r_v0      <= n_v0;
            r_v1      <= r_v0;
            r_v2      <= r_v1;
            r_v3      <= r_v2;
            r_out_vld <= r_v3 && w_col_res.in_frame && w_row_res.in_frame;
        end
    end

    // Output payload: held only for the one cycle the strobe marks
    always_ff @(posedge i_clk) begin
        r_target.target_col <= w_col_res.coord;
        r_target.target_row <= w_row_res.coord;
    end

    assign o_busy   = r_busy;
    assign o_valid  = r_out_vld;
    assign o_target = r_target;

endmodule

// ===== hw/rtl/prr_checker.sv =====
`timescale 1ns / 1ps

module prr_checker
    import prr_pkg::*;
#(
    parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic       o_valid,
    input t_pixel_out o_target
);

    // A result always traces back to an earlier accepted pixel transfer
    a_valid_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, 5))
        else $error("result strobe without matching pixel transfer");

    // Reset flushes the pipe: no strobe in the cycle after a reset edge
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    a_col_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_target.target_col < IMAGE_WIDTH))
        else $error("target column outside frame");

    a_row_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_target.target_row < IMAGE_HEIGHT))
        else $error("target row outside frame");

endmodule

bind pixel_rotate_reproject_core prr_checker #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
) u_prr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_valid  (o_valid),
    .o_target (o_target)
);

// ===== bench/tb_pixel_rotate_reproject_core.sv =====
`timescale 1ns / 1ps

module tb_pixel_rotate_reproject_core;
    import prr_pkg::*;

    localparam int CX            = IMAGE_WIDTH_DEF / 2;
    localparam int CY            = IMAGE_HEIGHT_DEF / 2;
    localparam int ROT_FRAC_W    = 14;   // Q2.14 coefficients
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_ITEMS   = 150;
    localparam int RANDOM_PHASES = 9;

    // Index past the register list; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    t_pixel_in             i_pixel;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_valid;
    t_pixel_out            o_target;

    pixel_rotate_reproject_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_pixel    (i_pixel),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_target   (o_target)
    );

    // Shadow copy of the geometry registers, tracked from the write port.
    logic signed [ROT_W-1:0] rot_coef [6];
    logic [FOC_W-1:0]        focal_q;

    // Landing spots still owed by the block, oldest first.
    t_pixel_out landing_q [$];
    int         mismatches;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // One axis of the reprojection: exact sum at scale 2^22, truncated toward zero.
    function automatic longint project_axis(input logic signed [ROT_W-1:0] ka,
                                            input logic signed [ROT_W-1:0] kb,
                                            input logic signed [ROT_W-1:0] kc,
                                            input longint du, input longint dv,
                                            input longint centre);
        longint acc;
        acc = ((longint'(ka) * du + longint'(kb) * dv) <<< (FRAC_W - ROT_FRAC_W))
            + longint'(kc) * longint'(focal_q)
            + (centre <<< FRAC_W);
        return acc / (longint'(1) <<< FRAC_W);
    endfunction

    // Predict where a pixel lands; return 0 when the block gives nothing.
    function automatic bit reproject_pixel(input t_pixel_in px, output t_pixel_out tgt);
        longint du;
        longint dv;
        longint tc;
        longint tr;
        tgt = '0;
        // Drop unflagged pixels and pixels without depth.
        if (!px.vein_on || px.pixel_depth == '0)
            return 1'b0;
        du = longint'(px.pixel_col) - CX;
        dv = longint'(px.pixel_row) - CY;
        tc = project_axis(rot_coef[CFG_ROT_UU], rot_coef[CFG_ROT_UV], rot_coef[CFG_ROT_UZ],
                          du, dv, CX);
        tr = project_axis(rot_coef[CFG_ROT_VU], rot_coef[CFG_ROT_VV], rot_coef[CFG_ROT_VZ],
                          du, dv, CY);
        // Drop anything that lands outside the frame.
        if (tc < 0 || tc >= IMAGE_WIDTH_DEF || tr < 0 || tr >= IMAGE_HEIGHT_DEF)
            return 1'b0;
        tgt.target_col = COORD_W'(tc);
        tgt.target_row = COORD_W'(tr);
        return 1'b1;
    endfunction

    // Track register writes, predict every pixel transfer, check every result.
    always @(posedge i_clk) begin : landing_check
        t_pixel_out want;
        t_pixel_out tgt;
        if (!i_rst_n) begin
            rot_coef[CFG_ROT_UU] = ROT_ONE;
            rot_coef[CFG_ROT_UV] = ROT_ZERO;
            rot_coef[CFG_ROT_UZ] = ROT_ZERO;
            rot_coef[CFG_ROT_VU] = ROT_ZERO;
            rot_coef[CFG_ROT_VV] = ROT_ONE;
            rot_coef[CFG_ROT_VZ] = ROT_ZERO;
            focal_q              = FOCAL_RST;
        end else begin
            if (o_valid === 1'b1) begin
                if (landing_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result (%0d,%0d) with nothing expected",
                                 $realtime, o_target.target_col, o_target.target_row);
                end else begin
                    want = landing_q.pop_front();
                    if (o_target.target_col !== want.target_col ||
                        o_target.target_row !== want.target_row) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: target col exp %0d got %0d, row exp %0d got %0d",
                                     $realtime, want.target_col, o_target.target_col,
                                     want.target_row, o_target.target_row);
                    end
                end
            end
            if (i_cfg_we) begin
                // Rotation registers keep the low 16 bits; the spare index is ignored.
                if (i_cfg_idx == CFG_FOCAL)
                    focal_q = i_cfg_data;
                else if (i_cfg_idx < CFG_FOCAL)
                    rot_coef[i_cfg_idx] = i_cfg_data[ROT_W-1:0];
            end
            if (i_start && !o_busy) begin
                if (reproject_pixel(i_pixel, tgt))
                    landing_q.push_back(tgt);
            end
        end
    end

    // All drive tasks are entered and left at a falling edge.

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            // Hold start low and show junk the block must ignore.
            i_start <= 1'b0;
            i_pixel <= t_pixel_in'($urandom);
            repeat (n) @(negedge i_clk);
        end
    endtask

    // Present one pixel and hold it until the transfer edge has passed.
    task automatic send_pixel(input t_pixel_in px, input int gap);
        idle_cycles(gap);
        i_start <= 1'b1;
        i_pixel <= px;
        while (o_busy !== 1'b0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    // Wait until every owed result is in, then let trailing no-result pixels clear.
    task automatic drain_block();
        i_start <= 1'b0;
        while (landing_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
    endtask

    // Load a full geometry; random upper data bits check the 16-bit truncation.
    task automatic program_geometry(input logic [ROT_W-1:0] uu, input logic [ROT_W-1:0] uv,
                                    input logic [ROT_W-1:0] uz, input logic [ROT_W-1:0] vu,
                                    input logic [ROT_W-1:0] vv, input logic [ROT_W-1:0] vz,
                                    input logic [FOC_W-1:0] focal);
        write_reg(CFG_ROT_UU, {4'($urandom), uu});
        write_reg(CFG_ROT_UV, {4'($urandom), uv});
        write_reg(CFG_ROT_UZ, {4'($urandom), uz});
        write_reg(CFG_ROT_VU, {4'($urandom), vu});
        write_reg(CFG_ROT_VV, {4'($urandom), vv});
        write_reg(CFG_ROT_VZ, {4'($urandom), vz});
        write_reg(CFG_FOCAL, focal);
        write_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_pixel_in make_pixel(input int col, input int row,
                                             input int depth, input bit flag);
        t_pixel_in px;
        px.pixel_col   = COORD_W'(col);
        px.pixel_row   = COORD_W'(row);
        px.pixel_depth = DEPTH_W'(depth);
        px.vein_on     = flag;
        return px;
    endfunction

    // Mostly flagged pixels with depth, so most transfers reach the projection.
    function automatic t_pixel_in random_pixel();
        t_pixel_in px;
        px.pixel_col   = COORD_W'($urandom);
        px.pixel_row   = COORD_W'($urandom);
        px.pixel_depth = ($urandom_range(0, 99) < 6) ? '0 : DEPTH_W'($urandom_range(1, 65535));
        px.vein_on     = ($urandom_range(0, 99) < 85);
        return px;
    endfunction

    // Mostly back-to-back, sometimes a short gap, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [ROT_W-1:0] rand_coef(input int span);
        return ROT_W'($urandom_range(0, 2 * span) - span);
    endfunction

    // Reset geometry is identity: every in-frame pixel maps onto itself.
    task automatic test_reset_identity();
        send_pixel(make_pixel(0, 0, 1, 1'b1), 0);
        send_pixel(make_pixel(511, 511, 65535, 1'b1), 0);
        send_pixel(make_pixel(0, 511, 43690, 1'b1), pick_gap());
        send_pixel(make_pixel(511, 0, 21845, 1'b1), 0);
        send_pixel(make_pixel(CX, CY, 300, 1'b1), pick_gap());
    endtask

    task automatic test_flag_and_depth();
        send_pixel(make_pixel(100, 200, 0, 1'b1), 0);
        send_pixel(make_pixel(100, 200, 500, 1'b0), 0);
        send_pixel(make_pixel(0, 0, 0, 1'b0), 0);
        drain_block();
    endtask

    task automatic test_frame_edges();
        // Tiny negative focal term on columns: a column 0 pixel lands in (-1,0)
        // and truncates to 0. A row term just over one pixel pushes row 511 out.
        program_geometry(ROT_ONE, ROT_ZERO, 16'hFFFF, ROT_ZERO, ROT_ONE, 16'd33, FOCAL_RST);
        send_pixel(make_pixel(0, 10, 1, 1'b1), 0);
        send_pixel(make_pixel(0, 510, 7, 1'b1), 0);
        send_pixel(make_pixel(0, 511, 7, 1'b1), 0);
        drain_block();
        // Half turn about the centre: column and row 0 map to 512, one past the edge.
        program_geometry(16'hC000, ROT_ZERO, ROT_ZERO, ROT_ZERO, 16'hC000, ROT_ZERO, FOCAL_RST);
        send_pixel(make_pixel(0, 0, 9, 1'b1), 0);
        send_pixel(make_pixel(1, 1, 9, 1'b1), pick_gap());
        send_pixel(make_pixel(511, 511, 9, 1'b1), 0);
        drain_block();
    endtask

    task automatic test_config_extremes();
        // Largest coefficients of both signs, zero focal length.
        program_geometry(16'h7FFF, 16'h8000, ROT_ZERO, 16'h8000, 16'h7FFF, ROT_ZERO, '0);
        send_pixel(make_pixel(CX, CY, 1, 1'b1), 0);
        send_pixel(make_pixel(CX + 1, CY, 1, 1'b1), 0);
        send_pixel(make_pixel(CX, CY - 1, 1, 1'b1), 0);
        send_pixel(make_pixel(0, 511, 1, 1'b1), 0);
        drain_block();
        // Largest focal length with extreme focal coefficients: nothing lands.
        program_geometry(ROT_ONE, ROT_ZERO, 16'h7FFF, ROT_ZERO, ROT_ONE, 16'h8000, '1);
        send_pixel(make_pixel(CX, CY, 5, 1'b1), 0);
        send_pixel(make_pixel(0, 0, 5, 1'b1), 0);
        send_pixel(make_pixel(511, 511, 5, 1'b1), 0);
        send_pixel(make_pixel(511, 0, 5, 1'b1), 0);
        drain_block();
        // Largest focal length with the smallest tilt: a quarter-pixel shift,
        // lost on columns and pulling rows down by one.
        program_geometry(ROT_ONE, ROT_ZERO, 16'd1, ROT_ZERO, ROT_ONE, 16'hFFFF, '1);
        send_pixel(make_pixel(CX, CY, 5, 1'b1), 0);
        send_pixel(make_pixel(100, 400, 5, 1'b1), 0);
        send_pixel(make_pixel(447, 64, 5, 1'b1), 0);
        drain_block();
    endtask

    task automatic test_random_rotations();
        bit burst;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            burst = ($urandom_range(0, 2) == 0);
            if (ph == RANDOM_PHASES - 1)
                // Full-range geometry; few pixels land but every register bit toggles.
                program_geometry(ROT_W'($urandom), ROT_W'($urandom), ROT_W'($urandom),
                                 ROT_W'($urandom), ROT_W'($urandom), ROT_W'($urandom),
                                 FOC_W'($urandom));
            else
                // Rotation-like matrices keep a good share of the targets in frame.
                program_geometry(rand_coef(17000), rand_coef(17000), rand_coef(800),
                                 rand_coef(17000), rand_coef(17000), rand_coef(800),
                                 FOC_W'($urandom));
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_pixel(random_pixel(), burst ? 0 : pick_gap());
            drain_block();
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_start    = 1'b0;
        i_pixel    = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        mismatches = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_identity();
        test_flag_and_depth();
        test_frame_edges();
        test_config_extremes();
        test_random_rotations();
        drain_block();

        if (mismatches == 0 && landing_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Stop a hung run well past any correct completion time.
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
